FILE: rtl/core/ctm_pkg.sv
// ----------------------------------------------------------------------------
// ctm_pkg: shared types and constants for the color tolerant template match
// Command and register codes, fixed field widths, sequencer states and the
// structs that carry pipeline tags between the sequencer, store and matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ctm_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IDX_W      = 18;
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned COORD_W    = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned THR_W      = 17;
  localparam int unsigned SCR_CFG_W  = 10;
  localparam int unsigned TPL_CFG_W  = 6;
  localparam int unsigned TOL_W      = 8;
  localparam int unsigned FRAC_W     = 16;

  // Register reset values
  localparam logic [SCR_CFG_W-1:0] RST_SCREEN_W  = 10'd512;
  localparam logic [SCR_CFG_W-1:0] RST_SCREEN_H  = 10'd512;
  localparam logic [TPL_CFG_W-1:0] RST_TEMPL_W   = 6'd32;
  localparam logic [TPL_CFG_W-1:0] RST_TEMPL_H   = 6'd32;
  localparam logic [TOL_W-1:0]     RST_TOLERANCE = 8'd10;
  localparam logic [THR_W-1:0]     RST_THRESHOLD = 17'd58982;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_SCREEN = 2'd0,
    CMD_WR_TEMPL  = 2'd1,
    CMD_START     = 2'd2
  } ctm_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_W  = 3'd0,
    CFG_SCREEN_H  = 3'd1,
    CFG_TEMPL_W   = 3'd2,
    CFG_TEMPL_H   = 3'd3,
    CFG_TOLERANCE = 3'd4,
    CFG_THRESHOLD = 3'd5
  } ctm_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_NEED,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } ctm_state_e;

  // Tag that travels with each pixel pair read
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } ctm_tag_t;

  // Store write request
  typedef struct packed {
    logic             scr_en;
    logic             tpl_en;
    logic [IDX_W-1:0] index;
    logic [RGB_W-1:0] rgb;
  } ctm_wr_t;

  // Registered read data with its tag
  typedef struct packed {
    ctm_tag_t         tag;
    logic [RGB_W-1:0] scr;
    logic [RGB_W-1:0] tpl;
  } ctm_rsp_t;

  // Placement verdict / final report
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } ctm_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/ctm_intf.sv
// ----------------------------------------------------------------------------
// ctm_intf: channel interfaces of the template match block
// Item channel, result channel and configuration write channel, each with
// valid/ready and a source and sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctm_item_if import ctm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] pixel_index;
  logic [RGB_W-1:0] pixel_rgb;

  modport source (output valid, cmd, pixel_index, pixel_rgb, input ready);
  modport sink   (input valid, cmd, pixel_index, pixel_rgb, output ready);
endinterface

interface ctm_result_if import ctm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [COORD_W-1:0] match_x;
  logic [COORD_W-1:0] match_y;

  modport source (output valid, found, match_x, match_y, input ready);
  modport sink   (input valid, found, match_x, match_y, output ready);
endinterface

interface ctm_cfg_if import ctm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ctm_pixel_store.sv
// ----------------------------------------------------------------------------
// ctm_pixel_store: screen and template pixel memories
// One write port per memory for load transactions, one registered read port
// per memory for the scan; the read tag is registered alongside the data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_pixel_store import ctm_pkg::*; #(
  parameter int unsigned MAX_SCREEN_W = 512,
  parameter int unsigned MAX_SCREEN_H = 512,
  parameter int unsigned MAX_TEMPL_W  = 32,
  parameter int unsigned MAX_TEMPL_H  = 32,
  localparam int unsigned SDEPTH  = MAX_SCREEN_W * MAX_SCREEN_H,
  localparam int unsigned TDEPTH  = MAX_TEMPL_W * MAX_TEMPL_H,
  localparam int unsigned SADDR_W = (SDEPTH > 1) ? $clog2(SDEPTH) : 1,
  localparam int unsigned TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctm_wr_t             wr_i,
  input  wire ctm_tag_t            rd_i,
  input  wire logic [SADDR_W-1:0]  s_addr_i,
  input  wire logic [TADDR_W-1:0]  t_addr_i,
  input  wire logic                flush_i,
  output      ctm_rsp_t            rsp_o
);

  logic [RGB_W-1:0] scr_mem [SDEPTH];
  logic [RGB_W-1:0] tpl_mem [TDEPTH];

  logic             rd_valid_q;
  ctm_tag_t         tag_q;
  logic [RGB_W-1:0] scr_q;
  logic [RGB_W-1:0] tpl_q;

  // Load writes; indexes past the store are dropped
  always_ff @(posedge clk_i) begin
    if (wr_i.scr_en && (32'(wr_i.index) < SDEPTH)) begin
      scr_mem[SADDR_W'(wr_i.index)] <= wr_i.rgb;
    end
    if (wr_i.tpl_en && (32'(wr_i.index) < TDEPTH)) begin
      tpl_mem[TADDR_W'(wr_i.index)] <= wr_i.rgb;
    end
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    if (rd_i.valid) begin
      scr_q <= scr_mem[s_addr_i];
      tpl_q <= tpl_mem[t_addr_i];
    end
    tag_q <= rd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_i.valid && !flush_i;
    end
  end

  always_comb begin
    rsp_o           = '0;
    rsp_o.tag       = tag_q;
    rsp_o.tag.valid = rd_valid_q;
    rsp_o.scr       = scr_q;
    rsp_o.tpl       = tpl_q;
  end

endmodule

`default_nettype wire

FILE: rtl/core/ctm_match_unit.sv
// ----------------------------------------------------------------------------
// ctm_match_unit: shared pixel compare and match counter
// Compares one screen/template pixel pair per cycle, accumulates the count
// for the current placement and judges it against the threshold at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_match_unit import ctm_pkg::*; #(
  parameter int unsigned MAX_TEMPL_W = 32,
  parameter int unsigned MAX_TEMPL_H = 32,
  localparam int unsigned CNT_W  = $clog2(MAX_TEMPL_W * MAX_TEMPL_H + 1),
  localparam int unsigned NEED_W = THR_W + CNT_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctm_rsp_t           rsp_i,
  input  wire logic [TOL_W-1:0]   tol_i,
  input  wire logic [NEED_W-1:0]  need_i,
  input  wire logic               flush_i,
  output      ctm_res_t           res_o,
  output      logic               busy_o
);

  // All three channels within tolerance
  function automatic logic pixel_close(input logic [RGB_W-1:0] a,
                                       input logic [RGB_W-1:0] b,
                                       input logic [TOL_W-1:0] tol);
    logic       ok;
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] d;
    ok = 1'b1;
    for (int c = 0; c < 3; c++) begin
      ca = a[c*8 +: 8];
      cb = b[c*8 +: 8];
      d  = (ca >= cb) ? (ca - cb) : (cb - ca);
      if (d > tol) ok = 1'b0;
    end
    return ok;
  endfunction

  // Compare stage
  logic               a_valid_q;
  logic               a_last_q;
  logic               a_hit_q;
  logic [COORD_W-1:0] a_x_q;
  logic [COORD_W-1:0] a_y_q;

  // Count / verdict stage
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   total;
  logic               pass;
  logic               res_valid_q;
  logic               res_found_q;
  logic [COORD_W-1:0] res_x_q;
  logic [COORD_W-1:0] res_y_q;

  assign total = count_q + CNT_W'(a_hit_q);
  assign pass  = NEED_W'({total, {FRAC_W{1'b0}}}) >= need_i;

  always_ff @(posedge clk_i) begin
    a_last_q    <= rsp_i.tag.last;
    a_x_q       <= rsp_i.tag.x;
    a_y_q       <= rsp_i.tag.y;
    a_hit_q     <= pixel_close(rsp_i.scr, rsp_i.tpl, tol_i);
    res_found_q <= pass;
    res_x_q     <= a_x_q;
    res_y_q     <= a_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
      count_q     <= '0;
    end else if (flush_i) begin
      a_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      a_valid_q   <= rsp_i.tag.valid;
      res_valid_q <= a_valid_q && a_last_q;
      if (a_valid_q) begin
        count_q <= a_last_q ? '0 : total;
      end
    end
  end

  always_comb begin
    res_o       = '0;
    res_o.valid = res_valid_q;
    res_o.found = res_found_q;
    res_o.x     = res_x_q;
    res_o.y     = res_y_q;
  end

  assign busy_o = a_valid_q || res_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/ctm_scan_seq.sv
// ----------------------------------------------------------------------------
// ctm_scan_seq: placement scan sequencer
// Works out the pass level, walks placements and template pixels up to the first
// pass, issues one pixel pair read per cycle and collects the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_scan_seq import ctm_pkg::*; #(
  parameter int unsigned MAX_SCREEN_W = 512,
  parameter int unsigned MAX_SCREEN_H = 512,
  parameter int unsigned MAX_TEMPL_W  = 32,
  parameter int unsigned MAX_TEMPL_H  = 32,
  localparam int unsigned SW_W    = $clog2(MAX_SCREEN_W + 1),
  localparam int unsigned SH_W    = $clog2(MAX_SCREEN_H + 1),
  localparam int unsigned TW_W    = $clog2(MAX_TEMPL_W + 1),
  localparam int unsigned TH_W    = $clog2(MAX_TEMPL_H + 1),
  localparam int unsigned SDEPTH  = MAX_SCREEN_W * MAX_SCREEN_H,
  localparam int unsigned TDEPTH  = MAX_TEMPL_W * MAX_TEMPL_H,
  localparam int unsigned SADDR_W = (SDEPTH > 1) ? $clog2(SDEPTH) : 1,
  localparam int unsigned TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1,
  localparam int unsigned CNT_W   = $clog2(TDEPTH + 1),
  localparam int unsigned NEED_W  = THR_W + CNT_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SW_W-1:0]    sw_i,
  input  wire logic [SH_W-1:0]    sh_i,
  input  wire logic [TW_W-1:0]    tw_i,
  input  wire logic [TH_W-1:0]    th_i,
  input  wire logic [THR_W-1:0]   thr_i,
  input  wire ctm_res_t           res_i,
  input  wire logic               pipe_busy_i,
  input  wire logic               out_free_i,
  output      logic               idle_o,
  output      logic               flush_o,
  output      ctm_tag_t           rd_o,
  output      logic [SADDR_W-1:0] s_addr_o,
  output      logic [TADDR_W-1:0] t_addr_o,
  output      logic [NEED_W-1:0]  need_o,
  output      ctm_res_t           rep_o
);

  ctm_state_e         state_q, state_d;
  logic [SW_W-1:0]    x_q, x_d, xend_q, xend_d;
  logic [SH_W-1:0]    y_q, y_d, yend_q, yend_d;
  logic [TW_W-1:0]    tx_q, tx_d;
  logic [TH_W-1:0]    ty_q, ty_d;
  logic [SADDR_W-1:0] pbase_q, pbase_d;
  logic [SADDR_W-1:0] ybase_q, ybase_d;
  logic [SADDR_W-1:0] rbase_q, rbase_d;
  logic [TADDR_W-1:0] taddr_q, taddr_d;
  logic [CNT_W-1:0]   area_q, area_d;
  logic [NEED_W-1:0]  need_q, need_d;
  ctm_res_t           rep_q, rep_d;
  logic               tx_end, ty_end;

  assign tx_end = (tx_q == TW_W'(tw_i - 1'b1));
  assign ty_end = (ty_q == TH_W'(th_i - 1'b1));

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    xend_q  <= xend_d;
    yend_q  <= yend_d;
    tx_q    <= tx_d;
    ty_q    <= ty_d;
    pbase_q <= pbase_d;
    ybase_q <= ybase_d;
    rbase_q <= rbase_d;
    taddr_q <= taddr_d;
    area_q  <= area_d;
    need_q  <= need_d;
    rep_q   <= rep_d;
  end

  // Next state, scan walk and read issue
  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    y_d      = y_q;
    xend_d   = xend_q;
    yend_d   = yend_q;
    tx_d     = tx_q;
    ty_d     = ty_q;
    pbase_d  = pbase_q;
    ybase_d  = ybase_q;
    rbase_d  = rbase_q;
    taddr_d  = taddr_q;
    area_d   = area_q;
    need_d   = need_q;
    rep_d    = rep_q;
    rep_d.valid = 1'b0;
    flush_o  = 1'b0;
    rd_o       = '0;
    rd_o.x     = COORD_W'(x_q);
    rd_o.y     = COORD_W'(y_q);
    rd_o.last  = tx_end && ty_end;
    s_addr_o = rbase_q + SADDR_W'(tx_q);
    t_addr_o = taddr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d     = '0;
          y_d     = '0;
          tx_d    = '0;
          ty_d    = '0;
          pbase_d = '0;
          ybase_d = '0;
          rbase_d = '0;
          taddr_d = '0;
          state_d = ST_AREA;
        end
      end

      ST_AREA: begin
        area_d = CNT_W'(tw_i) * CNT_W'(th_i);
        xend_d = SW_W'(32'(sw_i) - 32'(tw_i));
        yend_d = SH_W'(32'(sh_i) - 32'(th_i));
        if ((32'(tw_i) > 32'(sw_i)) || (32'(th_i) > 32'(sh_i))) begin
          rep_d.found = 1'b0;
          rep_d.x     = '0;
          rep_d.y     = '0;
          state_d     = ST_REPORT;
        end else begin
          state_d = ST_NEED;
        end
      end

      ST_NEED: begin
        need_d  = NEED_W'(thr_i) * NEED_W'(area_q);
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        if (res_i.valid && res_i.found) begin
          flush_o     = 1'b1;
          rep_d.found = 1'b1;
          rep_d.x     = res_i.x;
          rep_d.y     = res_i.y;
          state_d     = ST_REPORT;
        end else begin
          rd_o.valid = 1'b1;
          if (!tx_end) begin
            tx_d    = tx_q + 1'b1;
            taddr_d = taddr_q + 1'b1;
          end else if (!ty_end) begin
            tx_d    = '0;
            ty_d    = ty_q + 1'b1;
            rbase_d = rbase_q + SADDR_W'(sw_i);
            taddr_d = taddr_q + 1'b1;
          end else begin
            // placement done: step right, then down, then stop
            tx_d    = '0;
            ty_d    = '0;
            taddr_d = '0;
            if (x_q != xend_q) begin
              x_d     = x_q + 1'b1;
              pbase_d = pbase_q + 1'b1;
              rbase_d = pbase_q + 1'b1;
            end else if (y_q != yend_q) begin
              x_d     = '0;
              y_d     = y_q + 1'b1;
              ybase_d = ybase_q + SADDR_W'(sw_i);
              pbase_d = ybase_q + SADDR_W'(sw_i);
              rbase_d = ybase_q + SADDR_W'(sw_i);
            end else begin
              state_d = ST_DRAIN;
            end
          end
        end
      end

      ST_DRAIN: begin
        if (res_i.valid && res_i.found) begin
          flush_o     = 1'b1;
          rep_d.found = 1'b1;
          rep_d.x     = res_i.x;
          rep_d.y     = res_i.y;
          state_d     = ST_REPORT;
        end else if (!pipe_busy_i) begin
          rep_d.found = 1'b0;
          rep_d.x     = '0;
          rep_d.y     = '0;
          state_d     = ST_REPORT;
        end
      end

      ST_REPORT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rep_o       = rep_q;
    rep_o.valid = (state_q == ST_REPORT) && out_free_i;
  end

  assign idle_o = (state_q == ST_IDLE);
  assign need_o = need_q;

endmodule

`default_nettype wire

FILE: rtl/core/color_tolerant_template_match_top.sv
// ----------------------------------------------------------------------------
// color_tolerant_template_match_top: tolerant template search over a screen
// Loads screen and template pixels, then finds the first placement whose
// count of color-matching template pixels reaches the threshold.
// ----------------------------------------------------------------------------
// Usage:
//   item_i   : cmd 0 writes a screen pixel, cmd 1 a template pixel, cmd 2
//              starts a search; cmd 3 is dropped. Loads return nothing;
//              ready stays high while no search runs.
//   result_o : one transaction per search: found, match_x, match_y.
//   cfg_i    : register writes (index 0..5), always ready; write only idle.
// Scan: placements are visited in order up to and including the first that
//   passes; when the template is larger than the screen, none is scanned
//   and the search reports not found.
//   The shared compare unit handles one pixel pair per cycle from the two
//   pixel memories, so the template area sets the cost of each placement.
//   Results of the compare pipeline are judged in order; a pass flushes the
//   reads already in flight.
// The result sits in an output register; loads are still taken while it
//   waits, and a new search holds its report until the register is free.
// Reset: registers return to their defaults; the pixel stores are not
//   cleared and read as unknown until written.
// ----------------------------------------------------------------------------
`default_nettype none

module color_tolerant_template_match_top import ctm_pkg::*; #(
  parameter int unsigned MAX_SCREEN_W = 512,
  parameter int unsigned MAX_SCREEN_H = 512,
  parameter int unsigned MAX_TEMPL_W  = 32,
  parameter int unsigned MAX_TEMPL_H  = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ctm_item_if.sink     item_i,
  ctm_result_if.source result_o,
  ctm_cfg_if.sink      cfg_i
);

  localparam int unsigned SW_W    = $clog2(MAX_SCREEN_W + 1);
  localparam int unsigned SH_W    = $clog2(MAX_SCREEN_H + 1);
  localparam int unsigned TW_W    = $clog2(MAX_TEMPL_W + 1);
  localparam int unsigned TH_W    = $clog2(MAX_TEMPL_H + 1);
  localparam int unsigned SDEPTH  = MAX_SCREEN_W * MAX_SCREEN_H;
  localparam int unsigned TDEPTH  = MAX_TEMPL_W * MAX_TEMPL_H;
  localparam int unsigned SADDR_W = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int unsigned TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(TDEPTH + 1);
  localparam int unsigned NEED_W  = THR_W + CNT_W;

  // Zero counts as one, anything past the maximum as the maximum
  function automatic logic [31:0] clamp_size(input logic [31:0] v,
                                             input logic [31:0] maxv);
    logic [31:0] r;
    r = v;
    if (v == 32'd0) r = 32'd1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // Configuration registers
  logic [SCR_CFG_W-1:0] screen_w_q, screen_h_q;
  logic [TPL_CFG_W-1:0] templ_w_q, templ_h_q;
  logic [TOL_W-1:0]     tol_q;
  logic [THR_W-1:0]     thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= RST_SCREEN_W;
      screen_h_q <= RST_SCREEN_H;
      templ_w_q  <= RST_TEMPL_W;
      templ_h_q  <= RST_TEMPL_H;
      tol_q      <= RST_TOLERANCE;
      thr_q      <= RST_THRESHOLD;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SCREEN_W:  screen_w_q <= cfg_i.data[SCR_CFG_W-1:0];
        CFG_SCREEN_H:  screen_h_q <= cfg_i.data[SCR_CFG_W-1:0];
        CFG_TEMPL_W:   templ_w_q  <= cfg_i.data[TPL_CFG_W-1:0];
        CFG_TEMPL_H:   templ_h_q  <= cfg_i.data[TPL_CFG_W-1:0];
        CFG_TOLERANCE: tol_q      <= cfg_i.data[TOL_W-1:0];
        CFG_THRESHOLD: thr_q      <= cfg_i.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes in use
  logic [SW_W-1:0] sw_use;
  logic [SH_W-1:0] sh_use;
  logic [TW_W-1:0] tw_use;
  logic [TH_W-1:0] th_use;

  assign sw_use = SW_W'(clamp_size(32'(screen_w_q), MAX_SCREEN_W));
  assign sh_use = SH_W'(clamp_size(32'(screen_h_q), MAX_SCREEN_H));
  assign tw_use = TW_W'(clamp_size(32'(templ_w_q), MAX_TEMPL_W));
  assign th_use = TH_W'(clamp_size(32'(templ_h_q), MAX_TEMPL_H));

  // Item channel decode
  logic    idle;
  logic    item_acc;
  logic    start;
  ctm_wr_t wr;

  assign item_i.ready = idle;
  assign item_acc     = item_i.valid && item_i.ready;
  assign start        = item_acc && (item_i.cmd == CMD_START);

  always_comb begin
    wr        = '0;
    wr.scr_en = item_acc && (item_i.cmd == CMD_WR_SCREEN);
    wr.tpl_en = item_acc && (item_i.cmd == CMD_WR_TEMPL);
    wr.index  = item_i.pixel_index;
    wr.rgb    = item_i.pixel_rgb;
  end

  // Core
  ctm_tag_t           rd;
  ctm_rsp_t           rsp;
  ctm_res_t           res;
  ctm_res_t           rep;
  logic [SADDR_W-1:0] s_addr;
  logic [TADDR_W-1:0] t_addr;
  logic [NEED_W-1:0]  need;
  logic               flush;
  logic               match_busy;
  logic               out_free;

  ctm_scan_seq #(
    .MAX_SCREEN_W (MAX_SCREEN_W),
    .MAX_SCREEN_H (MAX_SCREEN_H),
    .MAX_TEMPL_W  (MAX_TEMPL_W),
    .MAX_TEMPL_H  (MAX_TEMPL_H)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sw_i        (sw_use),
    .sh_i        (sh_use),
    .tw_i        (tw_use),
    .th_i        (th_use),
    .thr_i       (thr_q),
    .res_i       (res),
    .pipe_busy_i (rsp.tag.valid || match_busy),
    .out_free_i  (out_free),
    .idle_o      (idle),
    .flush_o     (flush),
    .rd_o        (rd),
    .s_addr_o    (s_addr),
    .t_addr_o    (t_addr),
    .need_o      (need),
    .rep_o       (rep)
  );

  ctm_pixel_store #(
    .MAX_SCREEN_W (MAX_SCREEN_W),
    .MAX_SCREEN_H (MAX_SCREEN_H),
    .MAX_TEMPL_W  (MAX_TEMPL_W),
    .MAX_TEMPL_H  (MAX_TEMPL_H)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_i     (rd),
    .s_addr_i (s_addr),
    .t_addr_i (t_addr),
    .flush_i  (flush),
    .rsp_o    (rsp)
  );

  ctm_match_unit #(
    .MAX_TEMPL_W (MAX_TEMPL_W),
    .MAX_TEMPL_H (MAX_TEMPL_H)
  ) u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rsp_i   (rsp),
    .tol_i   (tol_q),
    .need_i  (need),
    .flush_i (flush),
    .res_o   (res),
    .busy_o  (match_busy)
  );

  // Output register
  logic               out_valid_q;
  logic               out_found_q;
  logic [COORD_W-1:0] out_x_q;
  logic [COORD_W-1:0] out_y_q;

  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rep.valid) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rep.valid) begin
      out_found_q <= rep.found;
      out_x_q     <= rep.x;
      out_y_q     <= rep.y;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.found   = out_found_q;
  assign result_o.match_x = out_x_q;
  assign result_o.match_y = out_y_q;

  // Checks
  a_start_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !item_i.ready)
    else $error("item channel ready right after a search start");

  a_verdict_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !item_i.ready)
    else $error("placement verdict outside a search");

  a_report_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep.valid |-> (!out_valid_q || result_o.ready))
    else $error("report overwrote a pending result transaction");

  a_no_load_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd.valid |-> !(wr.scr_en || wr.tpl_en))
    else $error("pixel load during a scan read");

endmodule

`default_nettype wire
